[design/msdf_pkg.sv]
`default_nettype none

package msdf_pkg;

  // Image limits and derived widths.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int ADDR_W     = 20;
  localparam int DIST_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIST_W-1:0] DIST_INF = '1;
  localparam logic [30:0] Q_ONE   = 31'd65536;
  localparam logic [30:0] SAT_MAG = 31'h7FFF_FFFF;

  // Operation codes of an input beat.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_XF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YF     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_XL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_YL     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BAND   = 3'd7;

  // Memory read address selection.
  localparam logic [1:0] RS_OWN = 2'd0;
  localparam logic [1:0] RS_NB  = 2'd1;
  localparam logic [1:0] RS_PX  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       init;
    logic [1:0] rsel;
    logic       cap_own;
    logic       calc;
    logic       pos;
    logic       eval;
    logic       trunc;
    logic       emit;
  } msdf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic computed;
    logic empty_roi;
    logic pass_end;
    logic pos_wrap;
    logic xy_stale;
    logic div_done;
    logic need_norm;
    logic need_tdiv;
    logic out_free;
  } msdf_stat_t;

endpackage

`default_nettype wire

[design/msdf_in_if.sv]
`default_nettype none

interface msdf_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] mask_pixel;

  modport source (output valid, output opcode, output mask_pixel, input ready);
  modport sink (input valid, input opcode, input mask_pixel, output ready);
endinterface

`default_nettype wire

[design/msdf_out_if.sv]
`default_nettype none

interface msdf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sdf_value;
  logic        invalid;
  logic        saturated;
  logic        last;

  modport source (output valid, output sdf_value, output invalid, output saturated,
                  output last, input ready);
  modport sink (input valid, input sdf_value, input invalid, input saturated,
                input last, output ready);
endinterface

`default_nettype wire

[design/mask_signed_distance_field_top.sv]
`default_nettype none

// Channel   Dir  Beat contents
// in_ch     in   opcode, mask_pixel (load a mask pixel or request one result)
// out_ch    out  sdf_value, invalid, saturated, last
// cfg_*     in   write enable, register index, write data
//
// A read waits on the divider for each divide it
// needs (normalization, truncation, and once after a register write the position
// split by width). The first read after a load or register write first runs both
// distance passes unless the region is empty: three memory accesses per pixel in each pass
// on mask and distance memories that take one write and one read a cycle. Reset
// is asynchronous and needs no clearing pass. A stalled result holds in the output
// register and the block keeps taking loads.
module mask_signed_distance_field_top
  import msdf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  msdf_in_if.sink                    in_ch,
  msdf_out_if.source                 out_ch
);

  msdf_cmd_t  cmd;
  msdf_stat_t stat;

  msdf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_opcode_i (in_ch.opcode),
    .in_ready_o  (in_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  msdf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .mask_pixel_i  (in_ch.mask_pixel),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .out_value_o   (out_ch.sdf_value),
    .out_invalid_o (out_ch.invalid),
    .out_sat_o     (out_ch.saturated),
    .out_last_o    (out_ch.last)
  );

endmodule

`default_nettype wire

[design/msdf_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module msdf_div
  import msdf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [39:0] num_i,
  input  wire logic [15:0] den_i,
  output logic             done_o,
  output logic [39:0]      quo_o,
  output logic [15:0]      rem_o
);

  localparam int DIV_N  = 40;
  localparam int DIV_CW = $clog2(DIV_N + 1);

  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [39:0]       quo_q, quo_d;
  logic [15:0]       rem_q, rem_d;
  logic [15:0]       den_q, den_d;
  logic [16:0]       trial;

  // One shift-and-subtract step.
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, quo_q[DIV_N-1]};
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = 16'(trial - {1'b0, den_q});
        quo_d = {quo_q[DIV_N-2:0], 1'b1};
      end else begin
        rem_d = trial[15:0];
        quo_d = {quo_q[DIV_N-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_N - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

[design/msdf_ctrl.sv]
`default_nettype none

// Sequencer: loads, the two distance passes, and the read evaluation.
module msdf_ctrl
  import msdf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_opcode_i,
  output logic            in_ready_o,
  input  wire msdf_stat_t stat_i,
  output msdf_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_RD_OWN = 4'd2;
  localparam logic [3:0] S_RD_NB  = 4'd3;
  localparam logic [3:0] S_CALC   = 4'd4;
  localparam logic [3:0] S_POS    = 4'd5;
  localparam logic [3:0] S_XYDIV  = 4'd6;
  localparam logic [3:0] S_RD_PX  = 4'd7;
  localparam logic [3:0] S_EVAL   = 4'd8;
  localparam logic [3:0] S_NDIV   = 4'd9;
  localparam logic [3:0] S_TRUNC  = 4'd10;
  localparam logic [3:0] S_TDIV   = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rsel = RS_PX;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_opcode_i == OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            state_d = stat_i.computed ? S_POS : S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d = stat_i.empty_roi ? S_POS : S_RD_OWN;
      end
      S_RD_OWN: begin
        cmd_o.rsel = RS_OWN;
        state_d = S_RD_NB;
      end
      S_RD_NB: begin
        cmd_o.rsel    = RS_NB;
        cmd_o.cap_own = 1'b1;
        state_d = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d = stat_i.pass_end ? S_POS : S_RD_OWN;
      end
      S_POS: begin
        cmd_o.pos = 1'b1;
        state_d = (!stat_i.pos_wrap && stat_i.xy_stale) ? S_XYDIV : S_RD_PX;
      end
      S_XYDIV: begin
        if (stat_i.div_done) begin
          state_d = S_RD_PX;
        end
      end
      S_RD_PX: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = stat_i.need_norm ? S_NDIV : S_TRUNC;
      end
      S_NDIV: begin
        if (stat_i.div_done) begin
          state_d = S_TRUNC;
        end
      end
      S_TRUNC: begin
        cmd_o.trunc = 1'b1;
        state_d = stat_i.need_tdiv ? S_TDIV : S_EMIT;
      end
      S_TDIV: begin
        if (stat_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[design/msdf_dp.sv]
`default_nettype none

// Registers, mask and distance memories, pass arithmetic and result path.
module msdf_dp
  import msdf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [7:0]            mask_pixel_i,
  input  wire msdf_cmd_t             cmd_i,
  output msdf_stat_t                 stat_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [31:0]                out_value_o,
  output logic                       out_invalid_o,
  output logic                       out_sat_o,
  output logic                       out_last_o
);

  localparam logic [1:0] DV_XY    = 2'd0;
  localparam logic [1:0] DV_NORM  = 2'd1;
  localparam logic [1:0] DV_TRUNC = 2'd2;

  // Configuration registers.
  logic [10:0] w_q, h_q;
  logic [9:0]  xf_q, yf_q, xl_q, yl_q;
  logic [1:0]  mode_q;
  logic [15:0] band_q;

  logic [10:0] w_eff, h_eff;
  logic [9:0]  xl_eff, yl_eff;
  logic [15:0] band_eff;
  logic        empty;

  // Control state.
  logic [20:0]       total, base_q;
  logic [ADDR_W-1:0] lpos_q, rpos_q, lpos_eff;
  logic [9:0]        rx_q, ry_q;
  logic              stale_q, computed_q;
  logic [DIST_W-1:0] lm_q;
  logic [ADDR_W-1:0] idx_q;
  logic [9:0]        cx_q, cy_q;
  logic              bwd_q;
  logic              out_valid_q;

  // Payload registers.
  logic              own_m_q, left_m_q;
  logic [DIST_W-1:0] own_d_q, left_d_q;
  logic              in_roi_q, neg_q, sat_q, inv_q;
  logic [30:0]       mag_q;
  logic [1:0]        div_sel_q;
  logic [31:0]       out_value_q;
  logic              out_inv_q, out_sat_q, out_last_q;

  // Memories.
  logic              mask_mem [MAX_WIDTH*MAX_HEIGHT];
  logic [DIST_W-1:0] dist_mem [MAX_WIDTH*MAX_HEIGHT];
  logic              m_rd_q;
  logic [DIST_W-1:0] d_rd_q;
  logic [ADDR_W-1:0] raddr;

  logic [DIST_W-1:0] best0, best1, best;
  logic              vert_ok, hz_ok;
  logic              ev_in_roi, ev_sat, need_norm, trunc_big, need_tdiv, pos_wrap;
  logic              div_start, div_done;
  logic [39:0]       div_num, div_quo;
  logic [15:0]       div_den, div_rem;
  logic [1:0]        div_sel;
  logic [20:0]       rpos_nx, lpos_nx;
  logic [31:0]       mag_ext;

  function automatic logic [DIST_W-1:0] cand(logic m_here, logic m_nb,
                                             logic [DIST_W-1:0] d_nb,
                                             logic [DIST_W-1:0] cur);
    logic [DIST_W-1:0] c;
    c = cur;
    if (m_nb != m_here) begin
      c = DIST_W'(1);
    end else if (d_nb != DIST_INF) begin
      c = d_nb + 1'b1;
    end
    return (c < cur) ? c : cur;
  endfunction

  // Effective sizes, region and band.
  always_comb begin
    w_eff = (w_q == '0) ? 11'd1 : ((w_q > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : w_q);
    h_eff = (h_q == '0) ? 11'd1 : ((h_q > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : h_q);
    total = 21'(w_eff) * 21'(h_eff);
    xl_eff = ({1'b0, xl_q} > w_eff - 11'd1) ? 10'(w_eff - 11'd1) : xl_q;
    yl_eff = ({1'b0, yl_q} > h_eff - 11'd1) ? 10'(h_eff - 11'd1) : yl_q;
    band_eff = (band_q == '0) ? 16'd1 : band_q;
    empty = (xf_q > xl_eff) || (yf_q > yl_eff);
    lpos_eff = ({1'b0, lpos_q} >= total) ? '0 : lpos_q;
    lpos_nx = {1'b0, lpos_eff} + 21'd1;
    rpos_nx = {1'b0, rpos_q} + 21'd1;
    pos_wrap = ({1'b0, rpos_q} >= total);
  end

  // Pass neighbor candidates.
  always_comb begin
    vert_ok = bwd_q ? (cy_q < yl_eff) : (cy_q > yf_q);
    hz_ok   = bwd_q ? (cx_q < xl_eff) : (cx_q > xf_q);
    best0 = bwd_q ? own_d_q : DIST_INF;
    best1 = vert_ok ? cand(own_m_q, m_rd_q, d_rd_q, best0) : best0;
    best  = hz_ok ? cand(own_m_q, left_m_q, left_d_q, best1) : best1;
  end

  // Read evaluation and divider operand selection.
  always_comb begin
    ev_in_roi = (rx_q >= xf_q) && (rx_q <= xl_eff) && (ry_q >= yf_q) && (ry_q <= yl_eff);
    ev_sat    = (d_rd_q == DIST_INF);
    need_norm = ev_in_roi && !ev_sat && mode_q[0] && (lm_q != '0);
    trunc_big = neg_q && ({1'b0, mag_q} >= {8'd0, band_eff, 8'd0});
    need_tdiv = mode_q[1] && in_roi_q && !trunc_big;
    div_start = 1'b0;
    div_sel   = DV_XY;
    div_num   = {20'd0, rpos_q};
    div_den   = {5'd0, w_eff};
    if (cmd_i.pos && !pos_wrap && stale_q) begin
      div_start = 1'b1;
    end else if (cmd_i.eval && need_norm) begin
      div_start = 1'b1;
      div_sel   = DV_NORM;
      div_num   = {12'd0, d_rd_q, 16'd0} + {29'd0, lm_q[DIST_W-1:1]};
      div_den   = {4'd0, lm_q};
    end else if (cmd_i.trunc && need_tdiv) begin
      div_start = 1'b1;
      div_sel   = DV_TRUNC;
      div_num   = {1'b0, mag_q, 8'd0} + {25'd0, band_eff[15:1]};
      div_den   = band_eff;
    end
  end

  msdf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // Memory address selection.
  always_comb begin
    case (cmd_i.rsel)
      RS_OWN:  raddr = idx_q;
      RS_NB:   raddr = bwd_q ? idx_q + ADDR_W'(w_eff) : idx_q - ADDR_W'(w_eff);
      default: raddr = rpos_q;
    endcase
  end

  // Mask memory: written by loads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mask_mem[lpos_eff] <= (mask_pixel_i == 8'hFF);
    end
    m_rd_q <= mask_mem[raddr];
  end

  // Distance memory: written by both passes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      dist_mem[idx_q] <= best;
    end
    d_rd_q <= dist_mem[raddr];
  end

  // Configuration, positions, pass walk and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= 11'd1024;
      h_q         <= 11'd1024;
      xf_q        <= '0;
      yf_q        <= '0;
      xl_q        <= 10'd1023;
      yl_q        <= 10'd1023;
      mode_q      <= '0;
      band_q      <= 16'd256;
      base_q      <= '0;
      lpos_q      <= '0;
      rpos_q      <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      stale_q     <= 1'b0;
      computed_q  <= 1'b0;
      lm_q        <= '0;
      idx_q       <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      bwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      base_q  <= 21'(yf_q) * 21'(w_eff);

      if (cfg_we_i) begin
        computed_q <= 1'b0;
        stale_q    <= 1'b1;
        unique case (cfg_idx_i)
          REG_WIDTH:  w_q    <= cfg_data_i[10:0];
          REG_HEIGHT: h_q    <= cfg_data_i[10:0];
          REG_XF:     xf_q   <= cfg_data_i[9:0];
          REG_YF:     yf_q   <= cfg_data_i[9:0];
          REG_XL:     xl_q   <= cfg_data_i[9:0];
          REG_YL:     yl_q   <= cfg_data_i[9:0];
          REG_MODE:   mode_q <= cfg_data_i[1:0];
          REG_BAND:   band_q <= cfg_data_i;
          default:    band_q <= band_q;
        endcase
      end

      if (cmd_i.load) begin
        computed_q <= 1'b0;
        lpos_q     <= (lpos_nx >= total) ? '0 : lpos_nx[ADDR_W-1:0];
      end

      // Start of the forward pass.
      if (cmd_i.init) begin
        computed_q <= 1'b1;
        lm_q       <= '0;
        idx_q      <= ADDR_W'(base_q + {11'd0, xf_q});
        cx_q       <= xf_q;
        cy_q       <= yf_q;
        bwd_q      <= 1'b0;
      end

      // One pixel of a pass, then a raster step.
      if (cmd_i.calc) begin
        if (bwd_q && (best != DIST_INF) && (best > lm_q)) begin
          lm_q <= best;
        end
        if (!bwd_q) begin
          if (cx_q == xl_eff) begin
            if (cy_q == yl_eff) begin
              bwd_q <= 1'b1;
            end else begin
              cy_q  <= cy_q + 1'b1;
              cx_q  <= xf_q;
              idx_q <= idx_q + ADDR_W'(w_eff) - ADDR_W'(xl_eff - xf_q);
            end
          end else begin
            cx_q  <= cx_q + 1'b1;
            idx_q <= idx_q + 1'b1;
          end
        end else if (cx_q == xf_q) begin
          if (cy_q != yf_q) begin
            cy_q  <= cy_q - 1'b1;
            cx_q  <= xl_eff;
            idx_q <= idx_q - ADDR_W'(w_eff) + ADDR_W'(xl_eff - xf_q);
          end
        end else begin
          cx_q  <= cx_q - 1'b1;
          idx_q <= idx_q - 1'b1;
        end
      end

      if (cmd_i.pos && pos_wrap) begin
        rpos_q  <= '0;
        rx_q    <= '0;
        ry_q    <= '0;
        stale_q <= 1'b0;
      end

      if (div_done && (div_sel_q == DV_XY)) begin
        rx_q    <= div_rem[9:0];
        ry_q    <= div_quo[9:0];
        stale_q <= 1'b0;
      end

      // Result beat leaves; read position steps in raster order.
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (rpos_nx >= total) begin
          rpos_q <= '0;
          rx_q   <= '0;
          ry_q   <= '0;
        end else begin
          rpos_q <= rpos_nx[ADDR_W-1:0];
          if ({1'b0, rx_q} + 11'd1 == w_eff) begin
            rx_q <= '0;
            ry_q <= ry_q + 1'b1;
          end else begin
            rx_q <= rx_q + 1'b1;
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign mag_ext = {1'b0, mag_q};

  // Payload path.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_own) begin
      own_m_q <= m_rd_q;
      own_d_q <= d_rd_q;
    end
    if (cmd_i.calc) begin
      left_m_q <= own_m_q;
      left_d_q <= best;
    end
    if (div_start) begin
      div_sel_q <= div_sel;
    end
    if (cmd_i.eval) begin
      in_roi_q <= ev_in_roi;
      inv_q    <= 1'b0;
      if (!ev_in_roi) begin
        neg_q <= 1'b0;
        sat_q <= 1'b0;
        mag_q <= '0;
      end else begin
        neg_q <= m_rd_q;
        sat_q <= ev_sat;
        if (ev_sat) begin
          mag_q <= mode_q[0] ? Q_ONE : SAT_MAG;
        end else begin
          mag_q <= {3'd0, d_rd_q, 16'd0};
        end
      end
    end
    if (div_done && (div_sel_q == DV_NORM)) begin
      mag_q <= div_quo[30:0];
    end
    if (div_done && (div_sel_q == DV_TRUNC)) begin
      mag_q <= (div_quo > {9'd0, Q_ONE}) ? Q_ONE : div_quo[30:0];
    end
    if (cmd_i.trunc && mode_q[1] && in_roi_q && trunc_big) begin
      inv_q <= 1'b1;
    end
    if (cmd_i.emit) begin
      out_value_q <= inv_q ? 32'h8000_0000 : (neg_q ? 32'(-mag_ext) : mag_ext);
      out_inv_q   <= inv_q;
      out_sat_q   <= sat_q;
      out_last_q  <= ({1'b0, rpos_q} == total - 21'd1);
    end
  end

  // Status toward the controller.
  always_comb begin
    stat_o.computed  = computed_q;
    stat_o.empty_roi = empty;
    stat_o.pass_end  = bwd_q && (cx_q == xf_q) && (cy_q == yf_q);
    stat_o.pos_wrap  = pos_wrap;
    stat_o.xy_stale  = stale_q;
    stat_o.div_done  = div_done;
    stat_o.need_norm = need_norm;
    stat_o.need_tdiv = need_tdiv;
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign out_invalid_o = out_inv_q;
  assign out_sat_o     = out_sat_q;
  assign out_last_o    = out_last_q;

endmodule

`default_nettype wire
